// ===== rtl/core/clt_pkg.sv =====
package clt_pkg;

  // Character codes the tokenizer reacts to.
  localparam logic [7:0] CH_M      = 8'h6D;
  localparam logic [7:0] CH_C      = 8'h63;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Maximum number of results one input transaction can cause.
  localparam int unsigned MAX_RES = 3;

  // Progress through the line prefix that gets stripped.
  typedef enum logic [3:0] {
    PFX_START = 4'b0001,
    PFX_M     = 4'b0010,
    PFX_MC    = 4'b0100,
    PFX_DONE  = 4'b1000
  } pfx_state_t;

  // Running tokenizer state.
  typedef struct packed {
    logic scanning;
    logic has_byte;
    logic quoted;
    logic escape;
    logic comment;
    logic cmd_pending;
  } tok_state_t;

  localparam tok_state_t TOK_RESET = '{
    scanning: 1'b0, has_byte: 1'b0, quoted: 1'b0,
    escape: 1'b0, comment: 1'b0, cmd_pending: 1'b1
  };

  // One result as delivered on the output channel.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       token_begin;
    logic       command_begin;
    logic       line_done;
    logic       last;
  } out_item_t;

  // Outcome of feeding one byte to the tokenizer.
  typedef struct packed {
    tok_state_t st;
    logic       emit;
    logic       tb;
    logic       cb;
  } tok_res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Process one byte against the tokenizer state.
  function automatic tok_res_t tok_process(input tok_state_t s, input logic [7:0] c);
    tok_res_t r;
    logic     sp;
    logic     go;
    logic     app;
    r      = '0;
    r.st   = s;
    sp     = is_space(c);
    go     = 1'b1;
    app    = 1'b0;
    if (s.comment) begin
      go = 1'b0;
    end else if (!s.scanning) begin
      if (sp) begin
        go = 1'b0;
      end else if (c == CH_SEMI) begin
        r.st.cmd_pending = 1'b1;
        go = 1'b0;
      end else if (c == CH_HASH) begin
        r.st.comment = 1'b1;
        go = 1'b0;
      end else begin
        r.st.scanning = 1'b1;
        r.st.quoted   = 1'b0;
        r.st.escape   = 1'b0;
        r.st.has_byte = 1'b0;
      end
    end
    if (go) begin
      if (r.st.escape) begin
        r.st.escape = 1'b0;
        app = 1'b1;
      end else if (c == CH_BSLASH) begin
        r.st.escape = 1'b1;
      end else if (c == CH_QUOTE) begin
        r.st.quoted = ~r.st.quoted;
      end else if (!r.st.quoted && sp) begin
        r.st.scanning = 1'b0;
      end else if (!r.st.quoted && (c == CH_SEMI)) begin
        r.st.scanning    = 1'b0;
        r.st.cmd_pending = 1'b1;
      end else if (!r.st.quoted && (c == CH_HASH)) begin
        r.st.scanning = 1'b0;
        r.st.comment  = 1'b1;
      end else begin
        app = 1'b1;
      end
    end
    if (app) begin
      r.emit = 1'b1;
      r.tb   = ~r.st.has_byte;
      r.cb   = r.tb & r.st.cmd_pending;
      if (r.cb) begin
        r.st.cmd_pending = 1'b0;
      end
      r.st.has_byte = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/clt_if.sv =====
// Input channel: one line byte or an end-of-line marker per transaction.
interface clt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_line;

  modport source (output valid, output text_byte, output end_of_line, input ready);
  modport sink (input valid, input text_byte, input end_of_line, output ready);
endinterface

// Result channel: one token byte or the end-of-line result per transaction.
interface clt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       token_begin;
  logic       command_begin;
  logic       line_done;
  logic       last;

  modport source (output valid, output out_byte, output token_begin,
                  output command_begin, output line_done, output last, input ready);
  modport sink (input valid, input out_byte, input token_begin,
                input command_begin, input line_done, input last, output ready);
endinterface

// ===== rtl/core/clt_step.sv =====
module clt_step
  import clt_pkg::*;
(
  input  logic [7:0] in_byte,
  input  logic       in_eol,
  input  pfx_state_t pfx,
  input  tok_state_t tok,
  input  logic [7:0] held0,
  input  logic [7:0] held1,
  output pfx_state_t pfx_nxt,
  output tok_state_t tok_nxt,
  output logic       held0_we,
  output logic       held1_we,
  output out_item_t  items [MAX_RES],
  output logic [1:0] item_cnt
);

  logic [7:0] b [3];
  logic [2:0] bv;
  tok_state_t s [4];
  tok_res_t   r [3];
  out_item_t  cand [4];
  logic [3:0] ce;

  // Decide which bytes go through the tokenizer, in order.
  always_comb begin
    b[0]     = held0;
    b[1]     = held1;
    b[2]     = in_byte;
    bv       = 3'b000;
    pfx_nxt  = PFX_DONE;
    held0_we = 1'b0;
    held1_we = 1'b0;
    if (in_eol) begin
      pfx_nxt = PFX_START;
      bv[0]   = (pfx == PFX_M) || (pfx == PFX_MC);
      bv[1]   = (pfx == PFX_MC);
    end else begin
      case (pfx)
        PFX_START: begin
          if (in_byte == CH_M) begin
            pfx_nxt  = PFX_M;
            held0_we = 1'b1;
          end else begin
            bv[2] = 1'b1;
          end
        end
        PFX_M: begin
          if (in_byte == CH_C) begin
            pfx_nxt  = PFX_MC;
            held1_we = 1'b1;
          end else begin
            bv[0] = 1'b1;
            bv[2] = 1'b1;
          end
        end
        PFX_MC: begin
          if (in_byte != CH_SEMI) begin
            bv = 3'b111;
          end
        end
        default: begin
          bv[2] = 1'b1;
        end
      endcase
    end
  end

  // Chain of up to three tokenizer steps.
  always_comb begin
    s[0] = tok;
    for (int k = 0; k < 3; k++) begin
      r[k] = tok_process(s[k], b[k]);
      if (bv[k]) begin
        s[k+1] = r[k].st;
      end else begin
        s[k+1] = s[k];
      end
    end
    tok_nxt = in_eol ? TOK_RESET : s[3];
  end

  // Candidate results, then packed to the front.
  always_comb begin
    logic [1:0] n;
    n = 2'd0;
    for (int k = 0; k < 3; k++) begin
      cand[k] = '{out_byte: b[k], token_begin: r[k].tb, command_begin: r[k].cb,
                  line_done: 1'b0, last: 1'b0};
      ce[k]   = bv[k] & r[k].emit;
    end
    cand[3] = '{out_byte: 8'h00, token_begin: 1'b0, command_begin: 1'b0,
                line_done: 1'b1, last: 1'b0};
    ce[3]   = in_eol;
    for (int i = 0; i < MAX_RES; i++) begin
      items[i] = '0;
    end
    for (int k = 0; k < 4; k++) begin
      if (ce[k] && (n != 2'd3)) begin
        items[n] = cand[k];
        n        = n + 2'd1;
      end
    end
    if (n != 2'd0) begin
      items[n - 2'd1].last = 1'b1;
    end
    item_cnt = n;
  end

endmodule

// ===== rtl/core/clt_burst.sv =====
module clt_burst
  import clt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  out_item_t  load_items [MAX_RES],
  input  logic [1:0] load_cnt,
  output logic       can_load,
  clt_out_if.source  out_ch
);

  out_item_t  ent_r [MAX_RES];
  logic [1:0] cnt_r;
  logic       take;

  // The head entry drives the output channel.
  assign out_ch.valid         = (cnt_r != 2'd0);
  assign out_ch.out_byte      = ent_r[0].out_byte;
  assign out_ch.token_begin   = ent_r[0].token_begin;
  assign out_ch.command_begin = ent_r[0].command_begin;
  assign out_ch.line_done     = ent_r[0].line_done;
  assign out_ch.last          = ent_r[0].last;

  assign take     = out_ch.valid & out_ch.ready;
  assign can_load = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && take);

  // Result count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= load_cnt;
    end else if (take) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // Result entries: loaded as a group, shifted toward the head on each transaction.
  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= load_items;
    end else if (take) begin
      ent_r[0] <= ent_r[1];
      ent_r[1] <= ent_r[2];
    end
  end

endmodule

// ===== rtl/core/command_line_tokenizer.sv =====
// An input is registered first; its results then pass through the output buffer.
// Throughput: one input per cycle while each input yields at most one result and
// the output does not stall; more results hold the buffer until the last one is taken.
// Reset: synchronous, active low; clears the input valid flag and the result count and
// returns the tokenizer and prefix state to the start of a line.
module command_line_tokenizer
  import clt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  clt_in_if.sink   in_ch,
  clt_out_if.source out_ch
);

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_eol_r;
  pfx_state_t pfx_r;
  pfx_state_t pfx_nxt;
  tok_state_t tok_r;
  tok_state_t tok_nxt;
  logic [7:0] held_r [2];
  logic       held0_we;
  logic       held1_we;
  out_item_t  items [MAX_RES];
  logic [1:0] item_cnt;
  logic       can_load;
  logic       advance;

  assign advance     = in_v_r & can_load;
  assign in_ch.ready = ~in_v_r | advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.text_byte;
      in_eol_r  <= in_ch.end_of_line;
    end
  end

  // Tokenizer and prefix state, updated as each item moves to the output buffer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pfx_r <= PFX_START;
      tok_r <= TOK_RESET;
    end else if (advance) begin
      pfx_r <= pfx_nxt;
      tok_r <= tok_nxt;
    end
  end

  // Bytes held while the prefix is still open.
  always_ff @(posedge clk) begin
    if (advance && held0_we) begin
      held_r[0] <= in_byte_r;
    end
    if (advance && held1_we) begin
      held_r[1] <= in_byte_r;
    end
  end

  clt_step u_step (
    .in_byte  (in_byte_r),
    .in_eol   (in_eol_r),
    .pfx      (pfx_r),
    .tok      (tok_r),
    .held0    (held_r[0]),
    .held1    (held_r[1]),
    .pfx_nxt  (pfx_nxt),
    .tok_nxt  (tok_nxt),
    .held0_we (held0_we),
    .held1_we (held1_we),
    .items    (items),
    .item_cnt (item_cnt)
  );

  clt_burst u_burst (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .load_items (items),
    .load_cnt   (item_cnt),
    .can_load   (can_load),
    .out_ch     (out_ch)
  );

endmodule
